// ===== design/klt_pkg.sv =====
// ----------------------------------------------------------------------------
// klt_pkg
// shared types, constants and keyword table for the keyword lexer
// ----------------------------------------------------------------------------
package klt_pkg;

   localparam int WordBufferLen = 16;
   localparam int PosBits       = 16;
   localparam int NumKw         = 31;
   localparam int CntBits       = $clog2(WordBufferLen + 1);
   localparam int BufIdxBits    = $clog2(WordBufferLen);
   localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

   localparam logic [5:0] K_IDENT  = 6'd29;
   localparam logic [5:0] K_INT    = 6'd30;
   localparam logic [5:0] K_DEC    = 6'd31;
   localparam logic [5:0] K_STR    = 6'd32;
   localparam logic [5:0] K_ASSIGN = 6'd41;
   localparam logic [5:0] K_EQ     = 6'd42;
   localparam logic [5:0] K_NE     = 6'd43;
   localparam logic [5:0] K_GT     = 6'd44;
   localparam logic [5:0] K_GE     = 6'd45;
   localparam logic [5:0] K_LT     = 6'd46;
   localparam logic [5:0] K_LE     = 6'd47;
   localparam logic [5:0] K_DIV    = 6'd50;
   localparam logic [5:0] K_EOF    = 6'd53;
   localparam logic [5:0] K_NONE   = 6'd0;

   localparam logic [2:0] E_TOKEN   = 3'd0;
   localparam logic [2:0] E_COMMENT = 3'd1;
   localparam logic [2:0] E_STRING  = 3'd2;
   localparam logic [2:0] E_POINTS  = 3'd3;
   localparam logic [2:0] E_CHAR    = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_SLASH, S_LINEC, S_BLOCK, S_BSTAR, S_STRING, S_NUMBER,
      S_WORD, S_EQ, S_BANG, S_GT, S_LT, S_DOT
   } scan_state_type;

   // one result word
   typedef struct packed {
      logic [5:0]         kind;
      logic [2:0]         err;
      logic [PosBits-1:0] line;
      logic [PosBits-1:0] col;
      logic [PosBits-1:0] len;
      logic [7:0]         bad;
   } result_type;

   // what the front hands the back: up to two results; word results are
   // finished in the back by the keyword match
   typedef struct packed {
      logic                            cnt;     // 0: one result, 1: two
      logic                            w0;      // first result is a word
      logic                            w1;      // second result is a word
      logic [CntBits-1:0]              wlen;
      logic [WordBufferLen-1:0][7:0]   wbuf;
      result_type                      r0;
      result_type                      r1;
   } entry_type;

   typedef logic [8*WordBufferLen-1:0] kw_text_type;

   function automatic kw_text_type kw_str(input int i);
      kw_text_type t;
      t = '0;
      case (i)
         0:  t = kw_text_type'("incluir");
         1:  t = kw_text_type'("programa");
         2:  t = kw_text_type'({"fin", "_programa"});
         3:  t = kw_text_type'("configurar");
         4:  t = kw_text_type'({"fin", "_configurar"});
         5:  t = kw_text_type'({"bucle", "_principal"});
         6:  t = kw_text_type'({"fin", "_bucle"});
         7:  t = kw_text_type'("si");
         8:  t = kw_text_type'("entonces");
         9:  t = kw_text_type'("sino");
         10: t = kw_text_type'("fin_si");
         11: t = kw_text_type'("para");
         12: t = kw_text_type'("desde");
         13: t = kw_text_type'("hasta");
         14: t = kw_text_type'("hacer");
         15: t = kw_text_type'({"fin", "_para"});
         16: t = kw_text_type'("mientras");
         17: t = kw_text_type'({"fin", "_mientras"});
         18: t = kw_text_type'("repetir");
         19: t = kw_text_type'("veces");
         20: t = kw_text_type'("funcion");
         21: t = kw_text_type'({"fin", "_funcion"});
         22: t = kw_text_type'("retornar");
         23: t = kw_text_type'("entero");
         24: t = kw_text_type'("decimal");
         25: t = kw_text_type'("booleano");
         26: t = kw_text_type'("verdadero");
         27: t = kw_text_type'("falso");
         28: t = kw_text_type'({"configurar", "_pin"});
         29: t = kw_text_type'("escribir");
         30: t = kw_text_type'("esperar");
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [4:0] kw_len(input int i);
      logic [4:0] l;
      l = 5'd0;
      case (i)
         0: l = 5'd7;   1: l = 5'd8;   2: l = 5'd12;  3: l = 5'd10;
         4: l = 5'd14;  5: l = 5'd15;  6: l = 5'd9;   7: l = 5'd2;
         8: l = 5'd8;   9: l = 5'd4;   10: l = 5'd6;  11: l = 5'd4;
         12: l = 5'd5;  13: l = 5'd5;  14: l = 5'd5;  15: l = 5'd8;
         16: l = 5'd8;  17: l = 5'd12; 18: l = 5'd7;  19: l = 5'd5;
         20: l = 5'd7;  21: l = 5'd11; 22: l = 5'd8;  23: l = 5'd6;
         24: l = 5'd7;  25: l = 5'd8;  26: l = 5'd9;  27: l = 5'd5;
         28: l = 5'd14; 29: l = 5'd8;  30: l = 5'd7;
         default: l = 5'd0;
      endcase
      return l;
   endfunction

   function automatic logic [5:0] kw_kind(input int i);
      logic [5:0] k;
      if (i < 25) k = 6'(i);
      else if (i < 28) k = 6'(i + 1);
      else k = 6'(i + 5);
      return k;
   endfunction

   function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
      return (v == PosMax) ? v : v + 1'b1;
   endfunction

endpackage

// ===== design/keyword_lexer_tokenizer.sv =====
// ----------------------------------------------------------------------------
// keyword_lexer_tokenizer
// byte-serial lexer with keyword table, token and error reports
// ----------------------------------------------------------------------------
// path: the results of a taken word are written into the queue, then loaded
//   into the output register of the back end
// throughput: one input word per cycle while the queue is not full; one result
//   per cycle while rsp_ready is high; a two-result entry is popped after both
// reset: synchronous, returns to line 1 column 1 idle, queue emptied
module keyword_lexer_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_bad_byte,
   output logic        rsp_last_result
);
   import klt_pkg::*;

   logic       acc, push, nfull, nempty, pop;
   entry_type  pe, head;
   result_type r;

   assign req_ready = nfull;
   assign acc       = req_valid && req_ready;

   klt_front u_front (
      .clock, .reset, .in_valid(acc), .in_mode(req_mode), .in_byte(req_char_byte),
      .push, .push_entry(pe));

   klt_queue u_queue (
      .clock, .reset, .push, .push_entry(pe), .not_full(nfull),
      .not_empty(nempty), .pop, .head);

   klt_back u_back (
      .clock, .reset, .q_valid(nempty), .q_head(head), .q_pop(pop),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_res(r),
      .out_last(rsp_last_result));

   assign rsp_token_kind    = r.kind;
   assign rsp_error_code    = r.err;
   assign rsp_line_number   = r.line;
   assign rsp_column_number = r.col;
   assign rsp_token_length  = r.len;
   assign rsp_bad_byte      = r.bad;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> nfull) else $error("push into full queue");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> nempty) else $error("pop from empty queue");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != 16'd0) else $error("line zero");

endmodule

// ===== design/klt_front.sv =====
// ----------------------------------------------------------------------------
// klt_front
// scanner state machine: takes one byte per cycle while in_valid is high and builds raw results
// ----------------------------------------------------------------------------
module klt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_mode,
   input  logic [7:0]         in_byte,
   output logic               push,
   output klt_pkg::entry_type push_entry
);
   import klt_pkg::*;

   scan_state_type                state_ff, state_in;
   logic [PosBits-1:0]            line_ff, line_in;
   logic [PosBits-1:0]            col_ff, col_in;
   logic [PosBits-1:0]            start_ff, start_in;
   logic [PosBits-1:0]            count_ff, count_in;
   logic                          point_ff, point_in;
   logic [WordBufferLen-1:0][7:0] wbuf_ff, wbuf_in;

   result_type res [2];
   logic       isw [2];
   logic [1:0] n;

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
   endfunction
   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction
   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction
   function automatic logic [5:0] single_op(input logic [7:0] b);
      logic [5:0] k;
      case (b)
         "(": k = 6'd36;
         ")": k = 6'd37;
         "{": k = 6'd38;
         "}": k = 6'd39;
         ",": k = 6'd40;
         "+": k = 6'd48;
         "-": k = 6'd49;
         "*": k = 6'd51;
         ";": k = 6'd52;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   always_comb begin
      logic [7:0]  b;
      logic        do_idle;
      logic [5:0]  k;
      logic [5:0]  ek;
      logic [2:0]  ee;
      logic [PosBits-1:0] el, ec, en;
      logic [7:0]  eb;
      logic        ew;
      logic        fe;
      b        = in_byte;
      state_in = state_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      start_in = start_ff;
      count_in = count_ff;
      point_in = point_ff;
      wbuf_in  = wbuf_ff;
      res[0]   = '0;
      res[1]   = '0;
      isw[0]   = 1'b0;
      isw[1]   = 1'b0;
      n        = 2'd0;
      do_idle  = 1'b0;
      fe       = 1'b0;
      k        = K_NONE;
      ek = K_NONE; ee = E_TOKEN; el = line_ff; ec = col_ff; en = '0; eb = 8'd0;
      ew = 1'b0;

      // flush of the pending state, shared by several paths
      case (state_ff)
         S_SLASH: begin fe = 1'b1; ek = K_DIV; en = PosBits'(1); end
         S_BLOCK, S_BSTAR: begin fe = 1'b1; ee = E_COMMENT; end
         S_STRING: begin fe = 1'b1; ee = E_STRING; end
         S_NUMBER: begin
            fe = 1'b1; ek = point_ff ? K_DEC : K_INT; ec = start_ff; en = count_ff;
         end
         S_WORD: begin fe = 1'b1; ew = 1'b1; ec = start_ff; en = count_ff; end
         S_EQ: begin fe = 1'b1; ek = K_ASSIGN; en = PosBits'(1); end
         S_BANG: begin fe = 1'b1; ee = E_CHAR; eb = "!"; end
         S_GT: begin fe = 1'b1; ek = K_GT; en = PosBits'(1); end
         S_LT: begin fe = 1'b1; ek = K_LT; en = PosBits'(1); end
         S_DOT: begin fe = 1'b1; ee = E_CHAR; eb = "."; end
         default: fe = 1'b0;
      endcase

      if (in_mode) begin
         if (fe) begin
            res[0] = '{ek, ee, el, ec, en, eb};
            isw[0] = ew;
            n = 2'd1;
         end
         res[n[0]] = '{K_EOF, E_TOKEN, line_ff, fe && state_ff != S_NUMBER &&
                       state_ff != S_WORD && state_ff != S_BLOCK &&
                       state_ff != S_BSTAR && state_ff != S_STRING ?
                       sat_inc(col_ff) : col_ff, '0, 8'd0};
         n = n + 2'd1;
         state_in = S_IDLE;
         line_in  = PosBits'(1);
         col_in   = PosBits'(1);
         start_in = PosBits'(1);
         count_in = '0;
         point_in = 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: do_idle = 1'b1;
            S_SLASH: begin
               if (b == "/") state_in = S_LINEC;
               else if (b == "*") state_in = S_BLOCK;
               else do_idle = 1'b1;
            end
            S_LINEC: begin
               if (b == 8'h0a) begin
                  line_in = sat_inc(line_ff); col_in = PosBits'(1); state_in = S_IDLE;
               end
            end
            S_BLOCK, S_BSTAR: begin
               if (state_ff == S_BSTAR && b == "/") state_in = S_IDLE;
               else begin
                  if (b == 8'h0a) begin
                     line_in = sat_inc(line_ff); col_in = PosBits'(1);
                  end else col_in = sat_inc(col_ff);
                  state_in = (b == "*") ? S_BSTAR : S_BLOCK;
               end
            end
            S_STRING: begin
               if (b == 8'h22) begin
                  res[0] = '{K_STR, E_TOKEN, line_ff, start_ff, count_ff, 8'd0};
                  n = 2'd1;
                  col_in = sat_inc(col_ff);
                  state_in = S_IDLE;
               end else if (b == 8'h0a) begin
                  res[0] = '{K_NONE, E_STRING, line_ff, col_ff, '0, 8'd0};
                  n = 2'd1;
                  line_in = sat_inc(line_ff); col_in = PosBits'(1);
                  state_in = S_IDLE;
               end else begin
                  count_in = sat_inc(count_ff);
                  col_in = sat_inc(col_ff);
               end
            end
            S_NUMBER: begin
               if (b == "." && point_ff) begin
                  res[0] = '{K_NONE, E_POINTS, line_ff, col_ff, '0, 8'd0};
                  res[1] = '{K_DEC, E_TOKEN, line_ff, start_ff, count_ff, 8'd0};
                  n = 2'd2;
                  state_in = S_DOT;
               end else if (is_digit(b) || b == ".") begin
                  if (b == ".") point_in = 1'b1;
                  count_in = sat_inc(count_ff);
                  col_in = sat_inc(col_ff);
               end else do_idle = 1'b1;
            end
            S_WORD: begin
               if (is_alpha(b) || is_digit(b) || b == "_") begin
                  if (count_ff < PosBits'(WordBufferLen))
                     wbuf_in[count_ff[BufIdxBits-1:0]] = b;
                  count_in = sat_inc(count_ff);
                  col_in = sat_inc(col_ff);
               end else do_idle = 1'b1;
            end
            S_EQ, S_BANG, S_GT, S_LT: begin
               if (b == "=") begin
                  case (state_ff)
                     S_EQ:    k = K_EQ;
                     S_BANG:  k = K_NE;
                     S_GT:    k = K_GE;
                     default: k = K_LE;
                  endcase
                  res[0] = '{k, E_TOKEN, line_ff, col_ff, PosBits'(2), 8'd0};
                  n = 2'd1;
                  col_in = sat_inc(sat_inc(col_ff));
                  state_in = S_IDLE;
               end else do_idle = 1'b1;
            end
            default: do_idle = 1'b1;
         endcase

         if (do_idle) begin
            // flush first (advances column for single-char pending forms)
            if (fe) begin
               res[0] = '{ek, ee, el, ec, en, eb};
               isw[0] = ew;
               n = 2'd1;
               if (state_ff != S_NUMBER && state_ff != S_WORD)
                  col_in = sat_inc(col_ff);
            end
            state_in = S_IDLE;
            if (is_space(b)) begin
               if (b == 8'h0a) begin
                  line_in = sat_inc(line_ff); col_in = PosBits'(1);
               end else col_in = sat_inc(col_in);
            end else begin
               start_in = col_in;
               count_in = '0;
               if (b == "/") state_in = S_SLASH;
               else if (b == 8'h22) begin
                  col_in = sat_inc(col_in); start_in = col_in; state_in = S_STRING;
               end else if (is_digit(b)) begin
                  count_in = PosBits'(1); point_in = 1'b0;
                  col_in = sat_inc(col_in); state_in = S_NUMBER;
               end else if (is_alpha(b) || b == "_") begin
                  wbuf_in[0] = b; count_in = PosBits'(1);
                  col_in = sat_inc(col_in); state_in = S_WORD;
               end else if (b == "=") state_in = S_EQ;
               else if (b == "!") state_in = S_BANG;
               else if (b == ">") state_in = S_GT;
               else if (b == "<") state_in = S_LT;
               else begin
                  k = single_op(b);
                  if (k != K_NONE)
                     res[n[0]] = '{k, E_TOKEN, line_in, col_in, PosBits'(1), 8'd0};
                  else
                     res[n[0]] = '{K_NONE, E_CHAR, line_in, col_in, '0, b};
                  n = n + 2'd1;
                  col_in = sat_inc(col_in);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         line_ff  <= PosBits'(1);
         col_ff   <= PosBits'(1);
         start_ff <= PosBits'(1);
         count_ff <= '0;
         point_ff <= 1'b0;
      end else if (in_valid) begin
         state_ff <= state_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         count_ff <= count_in;
         point_ff <= point_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) wbuf_ff <= wbuf_in;
   end

   always_comb begin
      push            = in_valid && n != 2'd0;
      push_entry.cnt  = n == 2'd2;
      push_entry.w0   = isw[0];
      push_entry.w1   = isw[1];
      push_entry.wlen = (count_ff > PosBits'(WordBufferLen)) ?
                        CntBits'(WordBufferLen + 1) : count_ff[CntBits-1:0];
      push_entry.wbuf = wbuf_ff;
      push_entry.r0   = res[0];
      push_entry.r1   = res[1];
   end

endmodule

// ===== design/klt_queue.sv =====
// ----------------------------------------------------------------------------
// klt_queue
// four-word queue between the scanner and the result stage
// ----------------------------------------------------------------------------
module klt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  klt_pkg::entry_type push_entry,
   output logic               not_full,
   output logic               not_empty,
   input  logic               pop,
   output klt_pkg::entry_type head
);
   import klt_pkg::*;

   entry_type  mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign not_full  = cnt_ff != 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign head      = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_entry;
   end

endmodule

// ===== design/klt_back.sv =====
// ----------------------------------------------------------------------------
// klt_back
// result stage: keyword match and output register; while out_ready is high, one result per cycle
// ----------------------------------------------------------------------------
module klt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  klt_pkg::entry_type          q_head,
   output logic                        q_pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output klt_pkg::result_type         out_res,
   output logic                        out_last
);
   import klt_pkg::*;

   logic       sel_ff;       // 1: second result of head next
   logic       valid_ff;
   result_type res_ff;
   logic       last_ff;

   result_type cur;
   logic       cur_w, cur_last, load;
   logic [5:0] wk;

   // keyword text stored first character in the low byte
   function automatic kw_text_type kw_str_le(input int i);
      kw_text_type s, r;
      int          l;
      s = kw_str(i);
      r = '0;
      l = int'(kw_len(i));
      for (int j = 0; j < WordBufferLen; j++)
         if (j < l) r[8*j +: 8] = s[8*(l-1-j) +: 8];
      return r;
   endfunction

   always_comb begin
      kw_text_type txt;
      txt = kw_text_type'(q_head.wbuf);
      wk = K_IDENT;
      for (int i = 0; i < NumKw; i++) begin
         if (CntBits'(kw_len(i)) == q_head.wlen) begin
            if ((txt & ((kw_text_type'(1) << (8 * kw_len(i))) - 1'b1)) ==
                kw_str_le(i))
               wk = kw_kind(i);
         end
      end
   end

   always_comb begin
      cur      = sel_ff ? q_head.r1 : q_head.r0;
      cur_w    = sel_ff ? q_head.w1 : q_head.w0;
      if (cur_w) cur.kind = wk;
      cur_last = sel_ff || !q_head.cnt;
      load     = q_valid && (!valid_ff || out_ready);
      q_pop    = load && cur_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (load) sel_ff <= !cur_last;
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= cur;
         last_ff <= cur_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_last  = last_ff;

endmodule

// ===== test/tb_keyword_lexer_tokenizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyword_lexer_tokenizer
// drives byte streams and end marks into the lexer, predicts every token and
// error report with a behavioral scanner and checks each result word in order
// ----------------------------------------------------------------------------
module tb_keyword_lexer_tokenizer;
   import klt_pkg::*;

   typedef struct {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [15:0] line;
      logic [15:0] col;
      logic [15:0] len;
      logic [7:0]  bad;
      logic        last;
   } token_type;

   localparam int WatchdogLimit = 20000;
   localparam string KwFin = "fin_";
   localparam string KwSep = "_";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [7:0]  req_char_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic [15:0] rsp_token_length;
   logic [7:0]  rsp_bad_byte;
   logic        rsp_last_result;

   keyword_lexer_tokenizer dut (.*);

   always #5 clock = ~clock;

   // scanner shadow state
   scan_state_type sc_state;
   logic [15:0] sc_line, sc_col, sc_start, sc_count;
   logic        sc_point;
   logic [7:0]  sc_buf[WordBufferLen];
   token_type   expected_tokens[$];
   token_type   step_out[$];

   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  timed_out = 1'b0;
   bit  sender_bursty = 1'b1;

   string kw_names[NumKw] = '{"incluir", "programa", {KwFin, "programa"},
      "configurar", {KwFin, "configurar"}, {"bucle", KwSep, "principal"},
      {KwFin, "bucle"}, "si", "entonces", "sino", "fin_si", "para", "desde",
      "hasta", "hacer", {KwFin, "para"}, "mientras", {KwFin, "mientras"},
      "repetir", "veces", "funcion", {KwFin, "funcion"}, "retornar",
      "entero", "decimal", "booleano", "verdadero", "falso",
      {"configurar", KwSep, "pin"}, "escribir", "esperar"};
   int kw_kinds[NumKw] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16,
      17, 18, 19, 20, 21, 22, 23, 24, 26, 27, 28, 33, 34, 35};

   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void push_token(logic [5:0] k, logic [2:0] e, logic [15:0] l,
                                      logic [15:0] c, logic [15:0] n, logic [7:0] b);
      token_type t;
      t.kind = k; t.err = e; t.line = l; t.col = c; t.len = n; t.bad = b;
      t.last = 1'b0;
      if (step_out.size() < 2) step_out.insert(step_out.size(), t);
   endfunction

   function automatic void op_token(logic [5:0] k, int n);
      push_token(k, E_TOKEN, sc_line, sc_col, 16'(n), 8'd0);
      sc_col = bump(sc_col);
      if (n == 2) sc_col = bump(sc_col);
   endfunction

   function automatic void bad_char(logic [7:0] b);
      push_token(K_NONE, E_CHAR, sc_line, sc_col, 16'd0, b);
      sc_col = bump(sc_col);
   endfunction

   function automatic logic [5:0] word_kind();
      bit hit;
      if (sc_count > WordBufferLen) return K_IDENT;
      for (int i = 0; i < NumKw; i++) begin
         if (kw_names[i].len() == sc_count) begin
            hit = 1'b1;
            for (int j = 0; j < sc_count; j++)
               if (kw_names[i][j] != sc_buf[j]) hit = 1'b0;
            if (hit) return 6'(kw_kinds[i]);
         end
      end
      return K_IDENT;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic [5:0] single_kind(logic [7:0] b);
      case (b)
         "(": return 6'd36;
         ")": return 6'd37;
         "{": return 6'd38;
         "}": return 6'd39;
         ",": return 6'd40;
         "+": return 6'd48;
         "-": return 6'd49;
         "*": return 6'd51;
         ";": return 6'd52;
         default: return K_NONE;
      endcase
   endfunction

   function automatic void scan_idle(logic [7:0] b);
      sc_state = S_IDLE;
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
         if (b == 8'd10) begin
            sc_line = bump(sc_line);
            sc_col = 16'd1;
         end else sc_col = bump(sc_col);
         return;
      end
      sc_start = sc_col;
      sc_count = 16'd0;
      if (b == "/") sc_state = S_SLASH;
      else if (b == "\"") begin
         sc_col = bump(sc_col);
         sc_start = sc_col;
         sc_state = S_STRING;
      end else if (is_digit(b)) begin
         sc_count = 16'd1;
         sc_point = 1'b0;
         sc_col = bump(sc_col);
         sc_state = S_NUMBER;
      end else if (is_alpha(b)) begin
         sc_buf[0] = b;
         sc_count = 16'd1;
         sc_col = bump(sc_col);
         sc_state = S_WORD;
      end else if (b == "=") sc_state = S_EQ;
      else if (b == "!") sc_state = S_BANG;
      else if (b == ">") sc_state = S_GT;
      else if (b == "<") sc_state = S_LT;
      else if (single_kind(b) != K_NONE) op_token(single_kind(b), 1);
      else bad_char(b);
   endfunction

   function automatic void scan_flush();
      case (sc_state)
         S_SLASH: op_token(K_DIV, 1);
         S_BLOCK, S_BSTAR: push_token(K_NONE, E_COMMENT, sc_line, sc_col, 16'd0, 8'd0);
         S_STRING: push_token(K_NONE, E_STRING, sc_line, sc_col, 16'd0, 8'd0);
         S_NUMBER: push_token(sc_point ? K_DEC : K_INT, E_TOKEN, sc_line, sc_start,
                              sc_count, 8'd0);
         S_WORD: push_token(word_kind(), E_TOKEN, sc_line, sc_start, sc_count, 8'd0);
         S_EQ: op_token(K_ASSIGN, 1);
         S_BANG: bad_char("!");
         S_GT: op_token(K_GT, 1);
         S_LT: op_token(K_LT, 1);
         S_DOT: bad_char(".");
         default: ;
      endcase
      sc_state = S_IDLE;
   endfunction

   function automatic void scanner_reset();
      sc_state = S_IDLE;
      sc_line = 16'd1; sc_col = 16'd1; sc_start = 16'd1; sc_count = 16'd0;
      sc_point = 1'b0;
   endfunction

   function automatic void scan_byte(logic [7:0] b);
      case (sc_state)
         S_IDLE: scan_idle(b);
         S_SLASH: begin
            if (b == "/") sc_state = S_LINEC;
            else if (b == "*") sc_state = S_BLOCK;
            else begin scan_flush(); scan_idle(b); end
         end
         S_LINEC: begin
            if (b == 8'd10) begin
               sc_line = bump(sc_line);
               sc_col = 16'd1;
               sc_state = S_IDLE;
            end
         end
         S_BLOCK, S_BSTAR: begin
            if (sc_state == S_BSTAR && b == "/") sc_state = S_IDLE;
            else begin
               if (b == 8'd10) begin
                  sc_line = bump(sc_line);
                  sc_col = 16'd1;
               end else sc_col = bump(sc_col);
               sc_state = (b == "*") ? S_BSTAR : S_BLOCK;
            end
         end
         S_STRING: begin
            if (b == "\"") begin
               push_token(K_STR, E_TOKEN, sc_line, sc_start, sc_count, 8'd0);
               sc_col = bump(sc_col);
               sc_state = S_IDLE;
            end else if (b == 8'd10) begin
               push_token(K_NONE, E_STRING, sc_line, sc_col, 16'd0, 8'd0);
               sc_line = bump(sc_line);
               sc_col = 16'd1;
               sc_state = S_IDLE;
            end else begin
               sc_count = bump(sc_count);
               sc_col = bump(sc_col);
            end
         end
         S_NUMBER: begin
            if (b == "." && sc_point) begin
               push_token(K_NONE, E_POINTS, sc_line, sc_col, 16'd0, 8'd0);
               scan_flush();
               sc_state = S_DOT;
            end else if (is_digit(b) || b == ".") begin
               if (b == ".") sc_point = 1'b1;
               sc_count = bump(sc_count);
               sc_col = bump(sc_col);
            end else begin scan_flush(); scan_idle(b); end
         end
         S_WORD: begin
            if (is_alpha(b) || is_digit(b)) begin
               if (sc_count < WordBufferLen) sc_buf[sc_count] = b;
               sc_count = bump(sc_count);
               sc_col = bump(sc_col);
            end else begin scan_flush(); scan_idle(b); end
         end
         S_EQ, S_BANG, S_GT, S_LT: begin
            if (b == "=") begin
               op_token(sc_state == S_EQ ? K_EQ : sc_state == S_BANG ? K_NE :
                        sc_state == S_GT ? K_GE : K_LE, 2);
               sc_state = S_IDLE;
            end else begin scan_flush(); scan_idle(b); end
         end
         default: begin scan_flush(); scan_idle(b); end
      endcase
   endfunction

   function automatic void predict_word(logic mode, logic [7:0] b);
      step_out.delete();
      if (mode) begin
         scan_flush();
         push_token(K_EOF, E_TOKEN, sc_line, sc_col, 16'd0, 8'd0);
         scanner_reset();
      end else scan_byte(b);
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_tokens.insert(expected_tokens.size(), step_out[i]);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // valid stays high between back-to-back words; this task drops it only for a gap
   task automatic send_word(logic mode, logic [7:0] b);
      int gap;
      gap = sender_bursty ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_char_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(mode, b);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      token_type e;
      if (reset) idle_cycles <= 0;
      else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result kind %0d err %0d", rsp_token_kind,
                           rsp_error_code);
            end else begin
               e = expected_tokens.pop_front();
               if (rsp_token_kind !== e.kind || rsp_error_code !== e.err ||
                   rsp_line_number !== e.line || rsp_column_number !== e.col ||
                   rsp_token_length !== e.len || rsp_bad_byte !== e.bad ||
                   rsp_last_result !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp k%0d e%0d l%0d c%0d n%0d b%0d z%0d got k%0d e%0d l%0d c%0d n%0d b%0d z%0d",
                        e.kind, e.err, e.line, e.col, e.len, e.bad, e.last,
                        rsp_token_kind, rsp_error_code, rsp_line_number,
                        rsp_column_number, rsp_token_length, rsp_bad_byte,
                        rsp_last_result);
               end
            end
         end
      end
   end

   // receiver stalls
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         rsp_ready <= 1'b1;
         @(negedge clock);
         gap = sender_bursty ? 0 : gap_len();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_keywords();
      foreach (kw_names[i]) begin
         send_text(kw_names[i]);
         send_word(1'b0, " ");
      end
      send_text({KwFin, "programaX configurar", KwSep,
                 "pinesx abcdefghijklmnopqrstu _A9z\n"});
      send_word(1'b1, 8'd0);
   endtask

   task automatic test_operators();
      send_text("(){},;+-*/ = == != ! > >= < <= =\n!x>y<z/");
      send_word(1'b1, 8'd0);
   endtask

   task automatic test_numbers_strings();
      send_text("0 9 12.5 1.2.3x 7.. \"ab c\" \"\" \"brk\n\"end");
      send_word(1'b1, 8'd0);
   endtask

   task automatic test_comments();
      send_text("a// line ** /*\nb/* x\n*y**/c/*");
      send_word(1'b1, 8'd0);
      send_text("/");
      send_word(1'b1, 8'd0);
      send_text("1.2.");
      send_word(1'b1, 8'd0);
      send_text("=");
      send_word(1'b1, 8'd0);
      send_word(1'b1, 8'd0);
   endtask

   task automatic test_odd_bytes();
      send_word(1'b0, 8'd0);
      send_word(1'b0, 8'd255);
      send_word(1'b0, 8'd128);
      send_word(1'b0, "#");
      send_word(1'b0, ".");
      send_word(1'b0, 8'd127);
      send_word(1'b1, 8'hFF);
      wait_drained();
   endtask

   task automatic send_fragment();
      int r;
      string s;
      r = $urandom_range(0, 99);
      if (r < 25) s = kw_names[$urandom_range(0, NumKw-1)];
      else if (r < 35) begin
         s = "";
         repeat ($urandom_range(1, 20))
            s = {s, string'(8'("a" + $urandom_range(0, 25)))};
      end else if (r < 45) s = $sformatf("%0d.%0d", $urandom_range(0, 999),
                                         $urandom_range(0, 99));
      else if (r < 52) s = $sformatf("%0d", $urandom_range(0, 99999));
      else if (r < 60) s = "\"txt 1\"";
      else if (r < 65) s = "// note\n";
      else if (r < 70) s = "/* a*\nb **/";
      else if (r < 85) begin
         case ($urandom_range(0, 7))
            0: s = "=="; 1: s = "!="; 2: s = ">="; 3: s = "<=";
            4: s = "("; 5: s = ";"; 6: s = "="; default: s = "<";
         endcase
      end else if (r < 90) s = "\n";
      else if (r < 93) s = "1.2.3";
      else begin
         send_word(1'b0, 8'($urandom_range(0, 255)));
         return;
      end
      send_text(s);
      if ($urandom_range(0, 2) != 0) send_word(1'b0, " ");
   endtask

   task automatic test_random();
      for (int blk = 0; blk < 12; blk++) begin
         sender_bursty = (blk % 4 == 3);
         repeat ($urandom_range(5, 12)) send_fragment();
         if (blk == 5) wait_drained();
         send_word(1'b1, 8'($urandom_range(0, 255)));
      end
      sender_bursty = 1'b0;
   endtask

   initial begin
      scanner_reset();
      foreach (sc_buf[i]) sc_buf[i] = 8'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      sender_bursty = 1'b0;
      test_keywords();
      test_operators();
      test_numbers_strings();
      test_comments();
      test_odd_bytes();
      test_random();
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
design/klt_pkg.sv
design/klt_front.sv
design/klt_queue.sv
design/klt_back.sv
design/keyword_lexer_tokenizer.sv
test/tb_keyword_lexer_tokenizer.sv
